// ===== design/skht_pkg.sv =====
// Shared types and constants for the string-key hash table.
package skht_pkg;

  localparam int unsigned HashW = 32;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_SEARCH = 2'd1,
    OP_DELETE = 2'd2,
    OP_NONE   = 2'd3
  } opcode_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_NOTFOUND = 3'd1,
    ST_DUP      = 3'd2,
    ST_FULL     = 3'd3,
    ST_TOOLONG  = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    SLOT_EMPTY   = 2'd0,
    SLOT_USED    = 2'd1,
    SLOT_DELETED = 2'd2
  } slot_e;

  typedef enum logic [3:0] {
    S_COLLECT,
    S_MOD,
    S_PROBE,
    S_CMP_ISSUE,
    S_CMP_WAIT,
    S_INS_CLR,
    S_INS_COPY,
    S_DEL_CLR,
    S_OUT
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic key_take;    // absorb one input beat into key/hash
    logic mod_start;   // latch hash and begin modulo
    logic probe_init;  // load probe index from home bucket
    logic probe_next;  // advance probe index
    logic cmp_init;    // restart byte compare at byte 0
    logic cmp_next;    // advance byte compare pointer
    logic ins_commit;  // write status/len/value of insert slot
    logic del_commit;  // mark slot deleted
    logic wr_clear;    // write zero byte at pointer
    logic wr_copy;     // write key byte at pointer
    logic key_clear;   // reset key length, hash, overflow
    logic res_load;    // load result register
    status_e res_status;
    logic res_slot;    // result carries probe index
    logic res_value;   // result carries slot value
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic    mod_done;
    slot_e   slot_state;  // status of probe slot
    logic    len_match;
    logic    byte_match;
    logic    cmp_end;     // pointer has reached key length
    logic    ptr_full;    // pointer reached KEY_LEN
    logic    probe_last;  // all buckets visited
    logic    overflow;
    opcode_e opcode;
  } sts_t;

endpackage

// ===== design/skht_ctrl.sv =====
// Sequencer for key collection, probe walk, compare and slot updates.
module skht_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            s_valid_i,
  input  logic            s_last_i,
  output logic            s_ready_o,
  input  logic            out_free_i,
  input  skht_pkg::sts_t  sts_i,
  output skht_pkg::cmd_t  cmd_o
);

  skht_pkg::state_e state_q, state_d;
  logic key_match;
  assign key_match = sts_i.len_match && sts_i.cmp_end && sts_i.byte_match;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= skht_pkg::S_COLLECT;
    end else begin
      state_q <= state_d;
    end
  end

  assign s_ready_o = (state_q == skht_pkg::S_COLLECT);

  always_comb begin
    state_d = state_q;
    case (state_q)
      skht_pkg::S_COLLECT: begin
        if (s_valid_i && s_last_i) state_d = skht_pkg::S_MOD;
      end
      skht_pkg::S_MOD: begin
        if (sts_i.overflow || sts_i.opcode == skht_pkg::OP_NONE) begin
          state_d = skht_pkg::S_OUT;
        end else if (sts_i.mod_done) begin
          state_d = skht_pkg::S_PROBE;
        end
      end
      skht_pkg::S_PROBE: begin
        if (sts_i.slot_state == skht_pkg::SLOT_USED) begin
          if (sts_i.len_match) state_d = skht_pkg::S_CMP_ISSUE;
          else if (sts_i.probe_last) state_d = skht_pkg::S_OUT;
        end else if (sts_i.opcode == skht_pkg::OP_INSERT) begin
          state_d = skht_pkg::S_INS_CLR;
        end else if (sts_i.slot_state == skht_pkg::SLOT_EMPTY || sts_i.probe_last) begin
          state_d = skht_pkg::S_OUT;
        end
      end
      skht_pkg::S_CMP_ISSUE: state_d = skht_pkg::S_CMP_WAIT;
      skht_pkg::S_CMP_WAIT: begin
        if (key_match) begin
          state_d = (sts_i.opcode == skht_pkg::OP_DELETE) ? skht_pkg::S_DEL_CLR
                                                          : skht_pkg::S_OUT;
        end else if (!sts_i.byte_match) begin
          state_d = sts_i.probe_last ? skht_pkg::S_OUT : skht_pkg::S_PROBE;
        end else begin
          state_d = skht_pkg::S_CMP_WAIT;
        end
      end
      skht_pkg::S_INS_CLR: begin
        if (sts_i.ptr_full) state_d = skht_pkg::S_INS_COPY;
      end
      skht_pkg::S_INS_COPY: begin
        if (sts_i.cmp_end) state_d = skht_pkg::S_OUT;
      end
      skht_pkg::S_DEL_CLR: begin
        if (sts_i.ptr_full) state_d = skht_pkg::S_OUT;
      end
      skht_pkg::S_OUT: begin
        if (out_free_i) state_d = skht_pkg::S_COLLECT;
      end
      default: state_d = skht_pkg::S_COLLECT;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    cmd_o.res_status = skht_pkg::ST_OK;
    case (state_q)
      skht_pkg::S_COLLECT: begin
        cmd_o.key_take = s_valid_i;
        cmd_o.mod_start = s_valid_i && s_last_i;
      end
      skht_pkg::S_MOD: begin
        cmd_o.probe_init = sts_i.mod_done;
        if (sts_i.overflow) cmd_o.res_status = skht_pkg::ST_TOOLONG;
        else cmd_o.res_status = skht_pkg::ST_NOTFOUND;
        cmd_o.res_load = sts_i.overflow || sts_i.opcode == skht_pkg::OP_NONE;
      end
      skht_pkg::S_PROBE: begin
        cmd_o.cmp_init = 1'b1;
        if (sts_i.slot_state == skht_pkg::SLOT_USED) begin
          if (!sts_i.len_match) begin
            cmd_o.probe_next = 1'b1;
            cmd_o.res_load = sts_i.probe_last;
          end
        end else if (sts_i.opcode != skht_pkg::OP_INSERT) begin
          cmd_o.probe_next = (sts_i.slot_state == skht_pkg::SLOT_DELETED);
          cmd_o.res_load = sts_i.slot_state == skht_pkg::SLOT_EMPTY || sts_i.probe_last;
        end
        cmd_o.res_status = (sts_i.opcode == skht_pkg::OP_INSERT) ? skht_pkg::ST_FULL
                                                                 : skht_pkg::ST_NOTFOUND;
      end
      skht_pkg::S_CMP_ISSUE: cmd_o.cmp_next = 1'b1;
      skht_pkg::S_CMP_WAIT: begin
        if (key_match) begin
          cmd_o.res_slot = 1'b1;
          if (sts_i.opcode == skht_pkg::OP_INSERT) begin
            cmd_o.res_status = skht_pkg::ST_DUP;
            cmd_o.res_load = 1'b1;
          end else if (sts_i.opcode == skht_pkg::OP_SEARCH) begin
            cmd_o.res_value = 1'b1;
            cmd_o.res_load = 1'b1;
          end else begin
            cmd_o.del_commit = 1'b1;
            cmd_o.cmp_init = 1'b1;
          end
        end else if (!sts_i.byte_match) begin
          cmd_o.probe_next = 1'b1;
          cmd_o.res_load = sts_i.probe_last;
          cmd_o.res_status = (sts_i.opcode == skht_pkg::OP_INSERT) ? skht_pkg::ST_FULL
                                                                   : skht_pkg::ST_NOTFOUND;
        end else begin
          cmd_o.cmp_next = 1'b1;
        end
      end
      skht_pkg::S_INS_CLR: begin
        cmd_o.wr_clear = 1'b1;
        cmd_o.cmp_next = !sts_i.ptr_full;
        cmd_o.cmp_init = sts_i.ptr_full;
        cmd_o.ins_commit = sts_i.ptr_full;
      end
      skht_pkg::S_INS_COPY: begin
        cmd_o.wr_copy = !sts_i.cmp_end;
        cmd_o.cmp_next = !sts_i.cmp_end;
        cmd_o.res_load = sts_i.cmp_end;
        cmd_o.res_slot = 1'b1;
      end
      skht_pkg::S_DEL_CLR: begin
        cmd_o.wr_clear = 1'b1;
        cmd_o.cmp_next = !sts_i.ptr_full;
        cmd_o.res_load = sts_i.ptr_full;
        cmd_o.res_slot = 1'b1;
      end
      skht_pkg::S_OUT: cmd_o.key_clear = out_free_i;
      default: cmd_o = '0;
    endcase
  end

endmodule

// ===== design/skht_dp.sv =====
// Key buffer, hash, modulo unit, slot store and result register.
module skht_dp #(
  parameter int unsigned BUCKETS = 16,
  parameter int unsigned KEY_LEN = 30
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [4:0]            bucket_size_i,
  input  logic [1:0]            opcode_i,
  input  logic [7:0]            key_char_i,
  input  logic signed [31:0]    value_i,
  input  skht_pkg::cmd_t        cmd_i,
  output skht_pkg::sts_t        sts_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  out_free_o,
  output logic [2:0]            status_o,
  output logic signed [31:0]    found_value_o,
  output logic [3:0]            found_slot_o,
  output logic [4:0]            element_count_o
);

  localparam int unsigned SW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int unsigned LW = $clog2(KEY_LEN + 1);
  localparam int unsigned KW = (KEY_LEN > 1) ? $clog2(KEY_LEN) : 1;
  localparam int unsigned NW = $clog2(BUCKETS + 1);
  localparam int unsigned MW = KW + SW;
  localparam int unsigned CW = $clog2(BUCKETS + 1);
  localparam int unsigned MDW = $clog2(skht_pkg::HashW + 1);

  // key collection
  logic [7:0] key_buf_q [KEY_LEN];
  logic [LW-1:0] key_len_q;
  logic [skht_pkg::HashW-1:0] hash_q;
  logic ovf_q;
  logic [1:0] op_q;
  logic signed [31:0] val_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_len_q <= '0;
      hash_q <= '0;
      ovf_q <= 1'b0;
    end else if (cmd_i.key_clear) begin
      key_len_q <= '0;
      hash_q <= '0;
      ovf_q <= 1'b0;
    end else if (cmd_i.key_take && key_char_i != 8'd0) begin
      if (key_len_q < LW'(KEY_LEN)) begin
        key_len_q <= key_len_q + 1'b1;
        hash_q <= (hash_q << 5) - hash_q + {24'd0, key_char_i};
      end else begin
        ovf_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.key_take && key_char_i != 8'd0 && key_len_q < LW'(KEY_LEN)) begin
      key_buf_q[key_len_q[KW-1:0]] <= key_char_i;
    end
    if (cmd_i.mod_start) begin
      op_q <= opcode_i;
      val_q <= value_i;
    end
  end

  // restoring modulo, one bit a cycle
  logic [NW-1:0] n_use;
  always_comb begin
    if (bucket_size_i == 5'd0) n_use = NW'(1);
    else if ({27'd0, bucket_size_i} > BUCKETS) n_use = NW'(BUCKETS);
    else n_use = NW'(bucket_size_i);
  end

  logic [skht_pkg::HashW-1:0] dvd_q;
  logic [NW-1:0] rem_q;
  logic [MDW-1:0] mcnt_q;
  logic [NW:0] rem_sh;
  assign rem_sh = {rem_q, dvd_q[skht_pkg::HashW-1]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mcnt_q <= '0;
    end else if (cmd_i.mod_start) begin
      mcnt_q <= MDW'(skht_pkg::HashW);
    end else if (mcnt_q != '0) begin
      mcnt_q <= mcnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mod_start) begin
      rem_q <= '0;
      dvd_q <= (hash_q << 5) - hash_q + ((key_char_i != 8'd0 && key_len_q < LW'(KEY_LEN))
               ? {24'd0, key_char_i} : '0) + ((key_char_i != 8'd0
               && key_len_q < LW'(KEY_LEN)) ? '0 : hash_q - ((hash_q << 5) - hash_q));
    end else if (mcnt_q != '0) begin
      dvd_q <= {dvd_q[skht_pkg::HashW-2:0], 1'b0};
      rem_q <= NW'((rem_sh >= {1'b0, n_use}) ? rem_sh - {1'b0, n_use} : rem_sh);
    end
  end

  // slot store
  logic [1:0] slot_st_q [BUCKETS];
  logic [LW-1:0] slot_len_q [BUCKETS];
  logic signed [31:0] slot_val_q [BUCKETS];
  logic [7:0] slot_mem [BUCKETS*KEY_LEN];
  logic [CW-1:0] count_q;

  logic [SW-1:0] idx_q;
  logic [NW-1:0] visit_q;
  logic [LW-1:0] ptr_q;
  logic [7:0] rd_q;
  logic [7:0] kb_q;
  logic [MW-1:0] addr;

  assign addr = MW'(idx_q) * MW'(KEY_LEN) + MW'(ptr_q[KW-1:0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < BUCKETS; i++) slot_st_q[i] <= skht_pkg::SLOT_EMPTY;
      count_q <= '0;
    end else if (cmd_i.ins_commit) begin
      slot_st_q[idx_q] <= skht_pkg::SLOT_USED;
      count_q <= count_q + 1'b1;
    end else if (cmd_i.del_commit) begin
      slot_st_q[idx_q] <= skht_pkg::SLOT_DELETED;
      if (count_q != '0) count_q <= count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ins_commit) begin
      slot_len_q[idx_q] <= key_len_q;
      slot_val_q[idx_q] <= val_q;
    end else if (cmd_i.del_commit) begin
      slot_len_q[idx_q] <= '0;
      slot_val_q[idx_q] <= '0;
    end
    if (cmd_i.wr_clear && ptr_q < LW'(KEY_LEN)) slot_mem[addr] <= 8'd0;
    else if (cmd_i.wr_copy) slot_mem[addr] <= key_buf_q[ptr_q[KW-1:0]];
    rd_q <= slot_mem[addr];
    kb_q <= key_buf_q[ptr_q[KW-1:0]];
  end

  // probe index and byte pointer; compare uses registered copies of the slot and key bytes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      visit_q <= '0;
      ptr_q <= '0;
    end else begin
      if (cmd_i.probe_init) begin
        idx_q <= SW'(rem_sh >= {1'b0, n_use} ? rem_sh - {1'b0, n_use} : rem_sh);
        visit_q <= NW'(1);
      end else if (cmd_i.probe_next) begin
        idx_q <= (NW'(idx_q) + 1'b1 >= n_use) ? '0 : idx_q + 1'b1;
        visit_q <= visit_q + 1'b1;
      end
      if (cmd_i.cmp_init) begin
        ptr_q <= '0;
      end else if (cmd_i.cmp_next) begin
        ptr_q <= ptr_q + 1'b1;
      end
    end
  end

  // an empty key matches any stored key of length zero without reading bytes
  assign sts_o.mod_done = (mcnt_q == MDW'(1));
  assign sts_o.slot_state = skht_pkg::slot_e'(slot_st_q[idx_q]);
  assign sts_o.len_match = (slot_len_q[idx_q] == key_len_q);
  assign sts_o.byte_match = (rd_q == kb_q) || (key_len_q == '0);
  assign sts_o.cmp_end = (ptr_q == key_len_q) || (key_len_q == '0);
  assign sts_o.ptr_full = (ptr_q == LW'(KEY_LEN));
  assign sts_o.probe_last = (visit_q >= n_use);
  assign sts_o.overflow = ovf_q;
  assign sts_o.opcode = skht_pkg::opcode_e'(op_q);

  // result register
  logic ov_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ov_q <= 1'b0;
    else if (cmd_i.res_load) ov_q <= 1'b1;
    else if (out_ready_i) ov_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_load) begin
      status_o <= cmd_i.res_status;
      found_value_o <= cmd_i.res_value ? slot_val_q[idx_q] : '0;
      found_slot_o <= cmd_i.res_slot ? 4'(idx_q) : 4'd0;
      element_count_o <= 5'(cmd_i.ins_commit ? count_q + 1'b1 : count_q);
    end
  end

  assign out_valid_o = ov_q;
  assign out_free_o = !ov_q || out_ready_i;

endmodule

// ===== design/string_key_hash_table_linear_probe.sv =====
// Top level of the string-key open-addressing hash table.
//
//  channel   dir  handshake             payload
//  s_axis    in   tvalid/tready         tdata {value,key_char,opcode}, tlast key_last
//  m_axis    out  tvalid/tready         tdata {element_count,found_slot,found_value,status}
//  cfg       in   cfg_we_i              cfg_wdata_i bucket_size
//
// Key bytes are taken one beat a cycle while a key is being collected. An
// overlong key or the unused opcode skips straight to the result. Otherwise
// the last beat starts a bit-serial modulo, then a probe walk one bucket at
// a time, with a byte compare where the lengths match. Insert adds a clear
// of the slot's KEY_LEN key bytes and a copy of the key; delete adds a clear
// of the KEY_LEN key bytes. The input stalls until the result register
// frees. Reset empties all slots.
module string_key_hash_table_linear_probe #(
  parameter int unsigned BUCKETS = 16,
  parameter int unsigned KEY_LEN = 30
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [4:0]  cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,  // opcode[1:0], key_char[9:2], value[41:10], zero
  input  logic        s_axis_tlast,  // key_last
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata   // status[2:0], found_value[34:3], slot[38:35], count[43:39]
);

  logic [4:0] bsize_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) bsize_q <= 5'd13;
    else if (cfg_we_i) bsize_q <= cfg_wdata_i;
  end

  skht_pkg::cmd_t cmd;
  skht_pkg::sts_t sts;
  logic out_free;
  logic [2:0] st;
  logic signed [31:0] fv;
  logic [3:0] fs;
  logic [4:0] ec;

  skht_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .s_valid_i(s_axis_tvalid), .s_last_i(s_axis_tlast), .s_ready_o(s_axis_tready),
    .out_free_i(out_free), .sts_i(sts), .cmd_o(cmd)
  );

  skht_dp #(.BUCKETS(BUCKETS), .KEY_LEN(KEY_LEN)) u_dp (
    .clk_i, .rst_ni,
    .bucket_size_i(bsize_q),
    .opcode_i(s_axis_tdata[1:0]), .key_char_i(s_axis_tdata[9:2]),
    .value_i(s_axis_tdata[41:10]),
    .cmd_i(cmd), .sts_o(sts),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready), .out_free_o(out_free),
    .status_o(st), .found_value_o(fv), .found_slot_o(fs), .element_count_o(ec)
  );

  assign m_axis_tdata = {4'd0, ec, fs, fv, st};

endmodule

// ===== sim/tb_string_key_hash_table_linear_probe.sv =====
// Self-checking testbench for the string-key linear-probe hash table.
module tb_string_key_hash_table_linear_probe;

  localparam int NumBuckets = 16;
  localparam int KeyMax     = 30;
  localparam int CycleLimit = 3000000;

  typedef struct packed {
    logic [4:0]  count;
    logic [3:0]  slot;
    logic [31:0] value;
    skht_pkg::status_e status;
  } answer_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [4:0]  cfg_wdata_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata;
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [47:0] m_axis_tdata;

  string_key_hash_table_linear_probe #(
    .BUCKETS(NumBuckets),
    .KEY_LEN(KeyMax)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  // Shadow of the table: key being collected and the bucket store.
  logic [31:0] key_hash;
  logic [7:0]  key_bytes[KeyMax];
  int          key_len;
  bit          key_ovf;
  skht_pkg::slot_e tab_state[NumBuckets];
  logic [7:0]  tab_key[NumBuckets][KeyMax];
  int          tab_len[NumBuckets];
  logic [31:0] tab_val[NumBuckets];
  int          used_cnt;
  logic [4:0]  bucket_reg;

  answer_t     pending_answers[$];
  int          errors = 0;
  int          cycles = 0;
  bit          hold_off;    // long receiver stall request
  bit          steady_rx;   // receiver never stalls

  // Keys the random part reuses so hits, duplicates and deletes happen.
  logic [7:0]  pool_key[8][KeyMax];
  int          pool_len[8];

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic int table_span();
    if (bucket_reg == 0) return 1;
    if (bucket_reg > NumBuckets) return NumBuckets;
    return bucket_reg;
  endfunction

  function automatic bit key_equal(int b);
    if (tab_len[b] != key_len) return 1'b0;
    for (int i = 0; i < key_len; i++)
      if (tab_key[b][i] != key_bytes[i]) return 1'b0;
    return 1'b1;
  endfunction

  // Walk the probe path for search/delete; -1 when no used bucket matches.
  function automatic int locate_key();
    int n;
    int b;
    n = table_span();
    b = key_hash % n;
    for (int i = 0; i < n; i++) begin
      if (tab_state[b] == skht_pkg::SLOT_EMPTY) return -1;
      if (tab_state[b] == skht_pkg::SLOT_USED && key_equal(b)) return b;
      b = (b + 1) % n;
    end
    return -1;
  endfunction

  // Fold one beat into the shadow and queue the answer on the last byte.
  task automatic predict_table(skht_pkg::opcode_e op, logic [7:0] ch, bit last,
                               logic [31:0] val);
    answer_t a;
    int n;
    int b;
    if (ch != 0) begin
      if (key_len < KeyMax) begin
        key_bytes[key_len] = ch;
        key_len++;
        key_hash = key_hash * 32'd31 + ch;
      end else begin
        key_ovf = 1'b1;
      end
    end
    if (!last) return;
    a = '0;
    a.status = skht_pkg::ST_OK;
    if (key_ovf) begin
      a.status = skht_pkg::ST_TOOLONG;
    end else if (op == skht_pkg::OP_INSERT) begin
      n = table_span();
      b = key_hash % n;
      a.status = skht_pkg::ST_FULL;
      for (int i = 0; i < n; i++) begin
        if (tab_state[b] != skht_pkg::SLOT_USED) begin
          tab_state[b] = skht_pkg::SLOT_USED;
          for (int j = 0; j < KeyMax; j++) tab_key[b][j] = j < key_len ? key_bytes[j] : 8'h00;
          tab_len[b] = key_len;
          tab_val[b] = val;
          used_cnt++;
          a.status = skht_pkg::ST_OK;
          a.slot = 4'(b);
          break;
        end
        if (key_equal(b)) begin
          a.status = skht_pkg::ST_DUP;
          a.slot = 4'(b);
          break;
        end
        b = (b + 1) % n;
      end
    end else if (op == skht_pkg::OP_SEARCH || op == skht_pkg::OP_DELETE) begin
      b = locate_key();
      if (b < 0) begin
        a.status = skht_pkg::ST_NOTFOUND;
      end else if (op == skht_pkg::OP_SEARCH) begin
        a.value = tab_val[b];
        a.slot = 4'(b);
      end else begin
        tab_state[b] = skht_pkg::SLOT_DELETED;
        tab_len[b] = 0;
        tab_val[b] = '0;
        for (int j = 0; j < KeyMax; j++) tab_key[b][j] = 8'h00;
        if (used_cnt > 0) used_cnt--;
        a.slot = 4'(b);
      end
    end else begin
      a.status = skht_pkg::ST_NOTFOUND;
    end
    a.count = 5'(used_cnt);
    pending_answers.push_back(a);
    key_hash = '0;
    key_len = 0;
    key_ovf = 1'b0;
  endtask

  // Send one beat and hold it until accepted, then record the prediction.
  // Valid stays high; the caller drops it before any idle gap.
  task automatic send_beat(skht_pkg::opcode_e op, logic [7:0] ch, bit last, logic [31:0] val);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'd0, val, ch, op};
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_table(op, ch, last, val);
  endtask

  // Bursty sender: gap of random length after a random burst.
  int burst_left;
  task automatic send_paced(skht_pkg::opcode_e op, logic [7:0] ch, bit last,
                            logic [31:0] val);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    send_beat(op, ch, last, val);
  endtask

  // Bytes past the buffer are a fixed nonzero filler for overlong keys.
  task automatic send_key(skht_pkg::opcode_e op, logic [7:0] k[KeyMax], int len,
                          logic [31:0] val);
    if (len == 0) begin
      send_paced(op, 8'h00, 1'b1, val);
      return;
    end
    for (int i = 0; i < len; i++) send_paced(op, i < KeyMax ? k[i] : 8'h5A, i == len - 1, val);
  endtask

  // Drop valid, wait for all answers, then let the block settle.
  task automatic drain_answers();
    s_axis_tvalid <= 1'b0;
    wait (pending_answers.size() == 0);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_bucket_size(logic [4:0] sz);
    drain_answers();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= sz;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    bucket_reg = sz;
  endtask

  task automatic make_key(output logic [7:0] k[KeyMax], output int len, input int max_len);
    len = $urandom_range(0, max_len);
    for (int i = 0; i < KeyMax; i++) k[i] = 8'($urandom_range(1, 255));
  endtask

  // Result checker with its own stall pattern.
  always @(posedge clk_i) begin
    answer_t got;
    answer_t want;
    if (m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[43:0];
      if (pending_answers.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors = errors + 1;
      end else begin
        want = pending_answers.pop_front();
        if (got.status !== want.status) begin
          $display("%0t: status exp %0d got %0d", $time, want.status, got.status);
          errors = errors + 1;
        end
        if (got.value !== want.value) begin
          $display("%0t: value exp %h got %h", $time, want.value, got.value);
          errors = errors + 1;
        end
        if (got.slot !== want.slot) begin
          $display("%0t: slot exp %0d got %0d", $time, want.slot, got.slot);
          errors = errors + 1;
        end
        if (got.count !== want.count) begin
          $display("%0t: count exp %0d got %0d", $time, want.count, got.count);
          errors = errors + 1;
        end
      end
    end
    if (!rst_ni || hold_off) m_axis_tready <= 1'b0;
    else if (steady_rx) m_axis_tready <= 1'b1;
    else m_axis_tready <= (cycles % 7 < 4) || ($urandom_range(0, 3) == 0);
  end

  // Directed: extremes of fields, every opcode, empty key, dup, full, too long.
  task automatic test_directed();
    logic [7:0] k[KeyMax];
    for (int i = 0; i < KeyMax; i++) k[i] = 8'hFF;
    send_key(skht_pkg::OP_SEARCH, k, 0, 32'h0);          // empty table, empty key
    send_key(skht_pkg::OP_INSERT, k, 0, 32'h8000_0000);  // empty key insert
    send_key(skht_pkg::OP_INSERT, k, 0, 32'h7FFF_FFFF);  // duplicate
    send_key(skht_pkg::OP_SEARCH, k, 0, 32'h0);
    send_key(skht_pkg::OP_INSERT, k, KeyMax, 32'hFFFF_FFFF);  // longest key
    send_key(skht_pkg::OP_SEARCH, k, KeyMax, 32'h0);
    send_key(skht_pkg::OP_INSERT, k, KeyMax + 1, 32'h1);      // too long
    for (int i = 0; i < KeyMax; i++) k[i] = 8'(i + 1);
    send_key(skht_pkg::OP_NONE, k, 3, 32'h5555_AAAA);         // unused opcode
    send_key(skht_pkg::OP_DELETE, k, 3, 32'h0);               // delete miss
    send_key(skht_pkg::OP_INSERT, k, 3, 32'hAAAA_5555);
    send_key(skht_pkg::OP_DELETE, k, 3, 32'h0);
    send_key(skht_pkg::OP_SEARCH, k, 3, 32'h0);
    // zero byte in the middle of a key appends nothing
    send_paced(skht_pkg::OP_INSERT, 8'h41, 1'b0, 32'h0);
    send_paced(skht_pkg::OP_INSERT, 8'h00, 1'b0, 32'h0);
    send_paced(skht_pkg::OP_INSERT, 8'h80, 1'b1, 32'h1234_5678);
    // fill a one-bucket table
    write_bucket_size(5'd1);
    send_key(skht_pkg::OP_INSERT, k, 5, 32'h9);
    send_key(skht_pkg::OP_INSERT, k, 6, 32'h9);
  endtask

  task automatic test_random(int ops, bit slow_rx);
    logic [7:0] k[KeyMax];
    int len;
    int p;
    int r;
    skht_pkg::opcode_e op;
    steady_rx = !slow_rx;
    for (int n = 0; n < ops; n++) begin
      r = $urandom_range(0, 99);
      op = r < 45 ? skht_pkg::OP_INSERT : r < 75 ? skht_pkg::OP_SEARCH :
           r < 95 ? skht_pkg::OP_DELETE : skht_pkg::OP_NONE;
      if ($urandom_range(0, 9) < 8) begin
        p = $urandom_range(0, 7);
        send_key(op, pool_key[p], pool_len[p], $urandom);
      end else begin
        make_key(k, len, $urandom_range(0, 9) == 0 ? KeyMax + 3 : 6);
        send_key(op, k, len, $urandom);
      end
    end
  endtask

  // Hold the receiver off long enough that the block stalls its input.
  task automatic test_backpressure();
    logic [7:0] k[KeyMax];
    int len;
    hold_off = 1'b1;
    fork
      begin
        repeat (600) @(posedge clk_i);
        hold_off = 1'b0;
      end
      for (int n = 0; n < 6; n++) begin
        make_key(k, len, 4);
        send_key(skht_pkg::OP_INSERT, k, len, $urandom);
      end
    join
    drain_answers();
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tlast = 1'b0;
    hold_off = 1'b0;
    steady_rx = 1'b0;
    burst_left = 0;
    key_hash = '0;
    key_len = 0;
    key_ovf = 1'b0;
    used_cnt = 0;
    bucket_reg = 5'd13;
    for (int b = 0; b < NumBuckets; b++) tab_state[b] = skht_pkg::SLOT_EMPTY;
    for (int p = 0; p < 8; p++) begin
      pool_len[p] = $urandom_range(0, 5);
      for (int i = 0; i < KeyMax; i++) pool_key[p][i] = 8'($urandom_range(1, 255));
    end
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_backpressure();
    write_bucket_size(5'd16);
    test_random(60, 1'b1);
    write_bucket_size(5'd0);
    test_random(20, 1'b0);
    write_bucket_size(5'd31);
    test_random(60, 1'b1);
    write_bucket_size(5'd3);
    test_random(40, 1'b0);
    write_bucket_size(5'd7);
    test_random(40, 1'b1);
    write_bucket_size(5'd16);
    test_random(40, 1'b0);

    drain_answers();
    repeat (200) @(posedge clk_i);
    if (errors == 0 && pending_answers.size() == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule
